### design/lrtf_pkg.sv
// Shared types and codes for the longest-remaining-time-first scheduler.
package lrtf_pkg;

  localparam int unsigned TimeW = 16;
  localparam logic [TimeW-1:0] TimeMax = '1;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_CLEAR = 2'd2
  } lrtf_kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } lrtf_state_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [TimeW-1:0] job_id;
    logic [TimeW-1:0] arrival_time;
    logic [TimeW-1:0] burst_time;
  } lrtf_cmd_t;

  typedef struct packed {
    logic [TimeW-1:0] ran_id;
    logic             idle;
    logic [TimeW-1:0] end_time;
    logic             finished;
    logic [TimeW-1:0] turnaround;
    logic [TimeW-1:0] waiting;
    logic             all_done;
  } lrtf_rslt_t;

  // Running best-so-far that walks down the cell row during a tick.
  typedef struct packed {
    logic             vld;    // token present at this stage
    logic             found;  // some runnable job seen so far
    logic             other;  // some loaded job with work, other than the best
    logic [TimeW-1:0] rem;
    logic [TimeW-1:0] id;
    logic [TimeW-1:0] arr;
    logic [TimeW-1:0] burst;
  } lrtf_tok_t;

endpackage

### design/lrtf_cell.sv
// One job slot of the scheduler row: holds a job and compares it against the passing token.
module lrtf_cell #(
  parameter int unsigned SLOT_W = 4,
  parameter int unsigned IDX    = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic                      dec_en_i,
  input  logic                      slot_vld_i,
  input  lrtf_pkg::lrtf_cmd_t       cmd_i,
  input  logic [lrtf_pkg::TimeW-1:0] cur_time_i,
  input  lrtf_pkg::lrtf_tok_t       tok_i,
  input  logic [SLOT_W-1:0]         slot_i,
  output lrtf_pkg::lrtf_tok_t       tok_o,
  output logic [SLOT_W-1:0]         slot_o
);
  import lrtf_pkg::*;

  localparam logic [SLOT_W-1:0] MySlot = SLOT_W'(IDX);

  logic [TimeW-1:0] id_q, arr_q, burst_q, rem_q;
  lrtf_tok_t        tok_d, tok_q;
  logic [SLOT_W-1:0] slot_d, slot_q;
  logic live, runnable, better;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      id_q    <= cmd_i.job_id;
      arr_q   <= cmd_i.arrival_time;
      burst_q <= cmd_i.burst_time;
      rem_q   <= cmd_i.burst_time;
    end else if (dec_en_i) begin
      rem_q <= rem_q - 1'b1;
    end
  end

  always_comb begin
    live     = slot_vld_i && (rem_q != '0);
    runnable = live && (arr_q <= cur_time_i);
    // strict compares keep the earlier slot on full ties
    better   = !tok_i.found || (rem_q > tok_i.rem) ||
               ((rem_q == tok_i.rem) && (id_q < tok_i.id));
    tok_d  = tok_i;
    slot_d = slot_i;
    if (runnable && better) begin
      tok_d.found = 1'b1;
      tok_d.other = tok_i.other | tok_i.found;
      tok_d.rem   = rem_q;
      tok_d.id    = id_q;
      tok_d.arr   = arr_q;
      tok_d.burst = burst_q;
      slot_d      = MySlot;
    end else if (live) begin
      tok_d.other = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      slot_q <= '0;
    end else begin
      tok_q  <= tok_d;
      slot_q <= slot_d;
    end
  end

  assign tok_o  = tok_q;
  assign slot_o = slot_q;

endmodule

### design/longest_remaining_time_first_scheduler_top.sv
// Top level of the longest-remaining-time-first scheduler: control and the cell row.
//
// Usage:
//  - One command word on cmd_i is taken at a clock edge where start is high and
//    busy is low. kind LOAD stores a job in the next free slot (ignored once all
//    MAX_JOBS slots hold jobs), CLEAR empties the table and zeroes time, TICK runs
//    one time unit. An unknown kind is taken and does nothing.
//  - LOAD and CLEAR finish in the cycle they are taken; busy stays low.
//  - A TICK sends a token down the row of MAX_JOBS cells, one cell per cycle.
//    Each cell compares its job with the best seen so far and passes the token
//    on. When the token leaves the last cell, the winner's remaining work is
//    decremented, time advances (saturating) and the result word is registered.
//  - A tick passes through the seed register and every cell of the row before
//    its result is registered; busy stays high until the result is registered,
//    so a new tick is taken only once the last one has finished.
//  - The result word is on rslt_o for exactly one cycle with rslt_valid_o high.
//    The receiver cannot stall it; only ticks produce results.
//  - Reset (rst_ni low, asynchronous) empties the table, zeroes time and drops
//    any tick in flight. Job slots themselves are not cleared.
module longest_remaining_time_first_scheduler_top #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  lrtf_pkg::lrtf_cmd_t  cmd_i,
  output lrtf_pkg::lrtf_rslt_t rslt_o,
  output logic                 rslt_valid_o
);
  import lrtf_pkg::*;

  localparam int unsigned SlotW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_JOBS + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(MAX_JOBS);

  lrtf_state_e state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [TimeW-1:0] time_q, time_d;
  logic             seed_vld_q;
  logic             accept, do_load, do_clear, do_tick, finish;

  lrtf_tok_t        tok    [MAX_JOBS+1];
  logic [SlotW-1:0] slot   [MAX_JOBS+1];
  logic [MAX_JOBS-1:0] wr_en, dec_en, slot_vld;

  lrtf_tok_t        last;
  lrtf_rslt_t       rslt_d, rslt_q;
  logic             rslt_vld_q;
  logic [TimeW-1:0] end_time, tat;

  assign accept   = start && !busy;
  assign do_load  = accept && (cmd_i.kind == KIND_LOAD);
  assign do_clear = accept && (cmd_i.kind == KIND_CLEAR);
  assign do_tick  = accept && (cmd_i.kind == KIND_TICK);
  assign last     = tok[MAX_JOBS];
  assign finish   = (state_q == ST_SCAN) && last.vld;

  // ---- control FSM ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (do_tick) state_d = ST_SCAN;
      ST_SCAN: if (finish)  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      time_q     <= '0;
      seed_vld_q <= 1'b0;
      rslt_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      time_q     <= time_d;
      seed_vld_q <= do_tick;
      rslt_vld_q <= finish;
    end
  end

  // ---- table count and time ----
  always_comb begin
    count_d = count_q;
    time_d  = time_q;
    if (do_clear) begin
      count_d = '0;
      time_d  = '0;
    end else if (do_load && (count_q != CntFull)) begin
      count_d = count_q + 1'b1;
    end else if (finish) begin
      time_d = end_time;
    end
  end

  // ---- per-slot strobes ----
  always_comb begin
    for (int i = 0; i < MAX_JOBS; i++) begin
      wr_en[i]    = do_load && (count_q == CntW'(i));
      slot_vld[i] = (CntW'(i) < count_q);
      dec_en[i]   = finish && last.found && (slot[MAX_JOBS] == SlotW'(i));
    end
  end

  // ---- seed token: nothing found yet ----
  always_comb begin
    tok[0]       = '0;
    tok[0].vld   = seed_vld_q;
    slot[0]      = '0;
  end

  // ---- cell row ----
  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
    lrtf_cell #(
      .SLOT_W (SlotW),
      .IDX    (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (wr_en[g]),
      .dec_en_i   (dec_en[g]),
      .slot_vld_i (slot_vld[g]),
      .cmd_i      (cmd_i),
      .cur_time_i (time_q),
      .tok_i      (tok[g]),
      .slot_i     (slot[g]),
      .tok_o      (tok[g+1]),
      .slot_o     (slot[g+1])
    );
  end

  // ---- result formation when the token leaves the row ----
  always_comb begin
    end_time = (time_q == TimeMax) ? time_q : time_q + 1'b1;
    // arrival never exceeds the pre-tick time, so this cannot underflow
    tat      = end_time - last.arr;
    rslt_d   = '0;
    rslt_d.end_time = end_time;
    if (last.found) begin
      rslt_d.ran_id   = last.id;
      rslt_d.all_done = !(last.other || (last.rem != TimeW'(1)));
      if (last.rem == TimeW'(1)) begin
        rslt_d.finished   = 1'b1;
        rslt_d.turnaround = tat;
        // time saturation can push this below zero; clamp
        rslt_d.waiting    = (tat >= last.burst) ? tat - last.burst : '0;
      end
    end else begin
      rslt_d.idle     = 1'b1;
      rslt_d.all_done = !last.other;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      rslt_q <= rslt_d;
    end
  end

  assign rslt_o       = rslt_q;
  assign rslt_valid_o = rslt_vld_q;

endmodule

### verif/tb.sv
// Self-checking testbench for the longest-remaining-time-first scheduler top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrtf_pkg::*;

  localparam int unsigned NumSlots  = 16;
  localparam int unsigned RandWords = 850;
  // Quiet cycles in a row before the run is called hung.
  localparam int unsigned HangLimit = 4000;
  // Kind code with no meaning; the block takes the word and drops it.
  localparam logic [1:0]  KindUnused = 2'd3;

  typedef struct {
    lrtf_cmd_t  cmd;
    bit         has_lit;  // expected report typed in below instead of predicted
    lrtf_rslt_t lit;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  lrtf_cmd_t  cmd_i;
  lrtf_rslt_t rslt_o;
  logic       rslt_valid_o;

  // Scheduler mirror: job table, fill level and the saturating clock.
  logic [TimeW-1:0] job_tbl_id    [NumSlots];
  logic [TimeW-1:0] job_tbl_arr   [NumSlots];
  logic [TimeW-1:0] job_tbl_burst [NumSlots];
  logic [TimeW-1:0] job_tbl_rem   [NumSlots];
  int unsigned      jobs_loaded;
  logic [TimeW-1:0] sched_now;

  // Tick reports predicted but not yet seen on the result port, oldest first.
  lrtf_rslt_t  pending_reports[$];
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned words_sent;

  longest_remaining_time_first_scheduler_top #(
    .MAX_JOBS(NumSlots)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .rslt_o      (rslt_o),
    .rslt_valid_o(rslt_valid_o)
  );

  // 10 ns clock, starts low.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic lrtf_cmd_t mk_cmd(input logic [1:0] kind, input logic [TimeW-1:0] id,
                                       input logic [TimeW-1:0] arr,
                                       input logic [TimeW-1:0] burst);
    lrtf_cmd_t c;
    c.kind         = kind;
    c.job_id       = id;
    c.arrival_time = arr;
    c.burst_time   = burst;
    return c;
  endfunction

  // Report of a tick that finds nothing runnable in an empty table.
  function automatic lrtf_rslt_t idle_report(input logic [TimeW-1:0] end_t);
    lrtf_rslt_t r;
    r          = '0;
    r.idle     = 1'b1;
    r.end_time = end_t;
    r.all_done = 1'b1;
    return r;
  endfunction

  function automatic bit work_left();
    bit left;
    left = 1'b0;
    for (int unsigned i = 0; i < jobs_loaded; i++) begin
      if (job_tbl_rem[i] != '0) left = 1'b1;
    end
    return left;
  endfunction

  // A word that changes nothing in the table (unknown kind, load into a full table).
  function automatic bit word_ignored(input lrtf_cmd_t c);
    return (c.kind == KindUnused) || (c.kind == KIND_LOAD && jobs_loaded == NumSlots);
  endfunction

  // Mirror one accepted command word; a tick yields a report.
  task automatic schedule_step(input lrtf_cmd_t c, output bit reported, output lrtf_rslt_t rep);
    int               best;
    logic [TimeW-1:0] tat;
    reported = 1'b0;
    rep      = '0;
    best     = -1;
    case (c.kind)
      KIND_LOAD: begin
        if (jobs_loaded < NumSlots) begin
          job_tbl_id[jobs_loaded]    = c.job_id;
          job_tbl_arr[jobs_loaded]   = c.arrival_time;
          job_tbl_burst[jobs_loaded] = c.burst_time;
          job_tbl_rem[jobs_loaded]   = c.burst_time;
          jobs_loaded++;
        end
      end
      KIND_CLEAR: begin
        jobs_loaded = 0;
        sched_now   = '0;
      end
      KIND_TICK: begin
        reported = 1'b1;
        // Most remaining work wins; equal work goes to the lower id, then lower slot.
        for (int i = 0; i < int'(jobs_loaded); i++) begin
          if (job_tbl_rem[i] != '0 && job_tbl_arr[i] <= sched_now) begin
            if (best < 0 || job_tbl_rem[i] > job_tbl_rem[best] ||
                (job_tbl_rem[i] == job_tbl_rem[best] && job_tbl_id[i] < job_tbl_id[best]))
              best = i;
          end
        end
        if (sched_now != TimeMax) sched_now = sched_now + 1'b1;
        if (best < 0) begin
          rep.idle = 1'b1;
        end else begin
          job_tbl_rem[best] = job_tbl_rem[best] - 1'b1;
          rep.ran_id        = job_tbl_id[best];
          if (job_tbl_rem[best] == '0) begin
            tat            = sched_now - job_tbl_arr[best];
            rep.finished   = 1'b1;
            rep.turnaround = tat;
            // Once the clock is pinned at its ceiling this can go below zero; floor it.
            rep.waiting    = (tat >= job_tbl_burst[best]) ? tat - job_tbl_burst[best] : '0;
          end
        end
        rep.end_time = sched_now;
        rep.all_done = !work_left();
      end
      default: ;
    endcase
  endtask

  // Mostly back to back, sometimes a short pause, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(8, 60);
  endfunction

  // Present one command word from the falling edge until the block takes it,
  // then update the mirror. Returns at the falling edge after acceptance with
  // start still high, so a following word goes out without a drop.
  task automatic send_word(input lrtf_cmd_t c, input bit no_gap, input bit has_lit,
                           input lrtf_rslt_t lit);
    int unsigned gap;
    bit          reported;
    lrtf_rslt_t  rep;
    gap = no_gap ? 0 : gap_len();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    cmd_i = c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (!word_ignored(c)) words_sent++;
    schedule_step(c, reported, rep);
    if (reported) pending_reports.push_back(has_lit ? lit : rep);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [TimeW-1:0] exp_v,
                             input logic [TimeW-1:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch, expected %h got %h", $time, name, exp_v, act_v);
    end
  endtask

  // Result side: the strobe can't be held off, so every strobed word is checked
  // against the oldest prediction at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rslt_valid_o || (start && !busy)) quiet_cycles <= 0;
    else                                  quiet_cycles <= quiet_cycles + 1;
    if (rslt_valid_o) begin
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: report with none pending, ran_id %h end_time %h",
                   $time, rslt_o.ran_id, rslt_o.end_time);
      end else begin
        check_field("ran_id",     pending_reports[0].ran_id,     rslt_o.ran_id);
        check_field("idle",       TimeW'(pending_reports[0].idle), TimeW'(rslt_o.idle));
        check_field("end_time",   pending_reports[0].end_time,   rslt_o.end_time);
        check_field("finished",   TimeW'(pending_reports[0].finished),
                    TimeW'(rslt_o.finished));
        check_field("turnaround", pending_reports[0].turnaround, rslt_o.turnaround);
        check_field("waiting",    pending_reports[0].waiting,    rslt_o.waiting);
        check_field("all_done",   TimeW'(pending_reports[0].all_done),
                    TimeW'(rslt_o.all_done));
        void'(pending_reports.pop_front());
      end
    end
  end

  // Hang detector: nothing taken and nothing reported for too long.
  initial begin
    while (quiet_cycles < HangLimit) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    stim_row_t   plan[$];
    stim_row_t   row;
    lrtf_rslt_t  no_lit;
    bit          quiet;
    int unsigned njobs;
    int unsigned budget;
    int unsigned ticks;
    int unsigned r;
    int unsigned arr;
    logic [TimeW-1:0] burst;

    start        = 1'b0;
    cmd_i        = '0;
    rst_ni       = 1'b0;
    jobs_loaded  = 0;
    sched_now    = '0;
    fail_count   = 0;
    quiet_cycles = 0;
    words_sent   = 0;
    no_lit       = '0;

    // Directed plan. Only the idle ticks on an empty table carry a typed-in report.
    row.has_lit = 1'b0;
    row.lit     = no_lit;
    row.cmd = mk_cmd(KIND_TICK, '0, '0, '0);
    row.has_lit = 1'b1;
    row.lit     = idle_report(16'd1);
    plan.push_back(row);
    row.has_lit = 1'b0;
    row.lit     = no_lit;
    // unknown kind with every field bit set: dropped
    row.cmd = mk_cmd(KindUnused, 16'hFFFF, 16'hFFFF, 16'hFFFF); plan.push_back(row);
    // two jobs of equal work at the id extremes: the low id wins the tie
    row.cmd = mk_cmd(KIND_LOAD, 16'hFFFF, 16'h0000, 16'd2);      plan.push_back(row);
    row.cmd = mk_cmd(KIND_LOAD, 16'h0000, 16'h0000, 16'd2);      plan.push_back(row);
    // arrives at the last time value, full burst
    row.cmd = mk_cmd(KIND_LOAD, 16'd5,    16'hFFFF, 16'hFFFF);   plan.push_back(row);
    // zero burst: stored, never runnable
    row.cmd = mk_cmd(KIND_LOAD, 16'd7,    16'h0000, 16'h0000);   plan.push_back(row);
    for (int unsigned i = 0; i < NumSlots - 4; i++) begin
      row.cmd = mk_cmd(KIND_LOAD, TimeW'(16'h0100 + i), TimeW'(i), 16'd1);
      plan.push_back(row);
    end
    // table full: this one would win every tick if it were stored
    row.cmd = mk_cmd(KIND_LOAD, 16'd1, 16'h0000, 16'hFFFF);      plan.push_back(row);
    for (int unsigned i = 0; i < 4; i++) begin
      row.cmd = mk_cmd(KIND_TICK, '0, '0, '0);
      plan.push_back(row);
    end
    row.cmd = mk_cmd(KIND_CLEAR, '0, '0, '0);                    plan.push_back(row);
    row.cmd = mk_cmd(KIND_TICK, '0, '0, '0);
    row.has_lit = 1'b1;
    row.lit     = idle_report(16'd1);
    plan.push_back(row);

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[k]) send_word(plan[k].cmd, 1'b0, plan[k].has_lit, plan[k].lit);

    // Random part: mostly clear, a batch of loads, then ticks until it drains or the
    // budget is spent, with mid-run loads for preemption and some junk words mixed in.
    words_sent = 0;
    while (words_sent < RandWords) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) != 0)
        send_word(mk_cmd(KIND_CLEAR, TimeW'($urandom), TimeW'($urandom), TimeW'($urandom)),
                  quiet, 1'b0, no_lit);
      r = $urandom_range(0, 99);
      if (r < 10)      njobs = 0;
      else if (r < 25) njobs = $urandom_range(14, 20);
      else             njobs = $urandom_range(1, 8);
      budget = $urandom_range(20, 60);
      ticks  = 0;
      while (njobs > 0 || (ticks < budget && (work_left() || ticks == 0))) begin
        r = $urandom_range(0, 99);
        if (njobs > 0 || r < 8) begin
          if (njobs > 0) njobs--;
          if ($urandom_range(0, 99) < 85) arr = sched_now + $urandom_range(0, 10);
          else                            arr = $urandom_range(0, 65535);
          if (arr > 65535) arr = 65535;
          r = $urandom_range(0, 99);
          if (r < 80)      burst = TimeW'($urandom_range(1, 6));
          else if (r < 90) burst = '0;
          else             burst = TimeW'($urandom);
          send_word(mk_cmd(KIND_LOAD, TimeW'($urandom), TimeW'(arr), burst), quiet, 1'b0,
                    no_lit);
        end else if (r < 12) begin
          send_word(mk_cmd(KindUnused, TimeW'($urandom), TimeW'($urandom), TimeW'($urandom)),
                    quiet, 1'b0, no_lit);
        end else begin
          send_word(mk_cmd(KIND_TICK, TimeW'($urandom), TimeW'($urandom), TimeW'($urandom)),
                    quiet, 1'b0, no_lit);
          ticks++;
        end
      end
      repeat ($urandom_range(0, 2))
        send_word(mk_cmd(KIND_TICK, '0, '0, '0), quiet, 1'b0, no_lit);
    end

    start = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    // let any stray report from a tick still in the row show up
    repeat (NumSlots + 4) @(posedge clk_i);
    if (fail_count == 0 && pending_reports.size() == 0) $display("TEST PASSED");
    else                                                 $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
design/lrtf_pkg.sv
design/lrtf_cell.sv
design/longest_remaining_time_first_scheduler_top.sv
verif/tb.sv
